// File: src/ntp_pkg.sv
// ----------------------------------------------------------------------------
// ntp_pkg: shared types and constants for the nucleotide triplet packer
// Request payloads, packing constants and the byte-to-base mapping.
// ----------------------------------------------------------------------------
package ntp_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic [1:0] group_size;
    logic       bad_symbol;
  } out_item_t;

  typedef logic [2:0] base_t;

  localparam base_t BASE_A   = 3'd0;
  localparam base_t BASE_C   = 3'd1;
  localparam base_t BASE_G   = 3'd2;
  localparam base_t BASE_N   = 3'd3;
  localparam base_t BASE_T   = 3'd4;
  localparam base_t BASE_BAD = 3'd5;

  localparam logic [7:0] RADIX       = 8'd5;
  localparam logic [7:0] RADIX_SQ    = 8'd25;
  localparam logic [7:0] PAIR_BASE   = 8'd125;
  localparam logic [7:0] SINGLE_BASE = 8'd150;
  localparam logic [7:0] CODE_BAD    = 8'd0;

  localparam logic [1:0] SIZE_SINGLE = 2'd1;
  localparam logic [1:0] SIZE_PAIR   = 2'd2;
  localparam logic [1:0] SIZE_TRIPLE = 2'd3;

  // case-insensitive ACGNT lookup, anything else maps to BASE_BAD
  function automatic base_t map_symbol(input logic [7:0] ch);
    base_t v;
    case (ch)
      8'h41, 8'h61: v = BASE_A;
      8'h43, 8'h63: v = BASE_C;
      8'h47, 8'h67: v = BASE_G;
      8'h4E, 8'h6E: v = BASE_N;
      8'h54, 8'h74: v = BASE_T;
      default:      v = BASE_BAD;
    endcase
    return v;
  endfunction

endpackage

// File: src/ntp_core.sv
// ----------------------------------------------------------------------------
// ntp_core: group state and code computation
// Holds up to two pending bases; forms the group code for one request.
// ----------------------------------------------------------------------------
module ntp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_fire,
  input  ntp_pkg::in_item_t  item,
  output logic               res_valid,
  output ntp_pkg::out_item_t res
);

  ntp_pkg::base_t first_r, first_nxt;
  ntp_pkg::base_t second_r, second_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           bad_r, bad_nxt;

  ntp_pkg::base_t v_raw;
  ntp_pkg::base_t v;
  logic           sym_bad;
  logic [7:0]     a8, b8, v8;
  logic [7:0]     code_raw;
  logic           grp_bad;

  assign v_raw   = ntp_pkg::map_symbol(item.symbol);
  assign sym_bad = (v_raw == ntp_pkg::BASE_BAD);
  assign v       = sym_bad ? ntp_pkg::BASE_A : v_raw;
  assign a8      = {5'd0, first_r};
  assign b8      = {5'd0, second_r};
  assign v8      = {5'd0, v};

  always_comb begin
    first_nxt      = first_r;
    second_nxt     = second_r;
    cnt_nxt        = cnt_r;
    bad_nxt        = bad_r;
    res_valid      = 1'b0;
    code_raw       = ntp_pkg::CODE_BAD;
    grp_bad        = bad_r;
    res.group_size = ntp_pkg::SIZE_TRIPLE;
    if (item.flush) begin
      if (cnt_r != 2'd0) begin
        res_valid = 1'b1;
        if (cnt_r == 2'd1) begin
          res.group_size = ntp_pkg::SIZE_SINGLE;
          code_raw       = ntp_pkg::SINGLE_BASE + a8;
        end else begin
          res.group_size = ntp_pkg::SIZE_PAIR;
          code_raw       = ntp_pkg::PAIR_BASE + ntp_pkg::RADIX * a8 + b8;
        end
        first_nxt  = ntp_pkg::BASE_A;
        second_nxt = ntp_pkg::BASE_A;
        cnt_nxt    = 2'd0;
        bad_nxt    = 1'b0;
      end
    end else begin
      case (cnt_r)
        2'd0: begin
          first_nxt = v;
          bad_nxt   = sym_bad;
          cnt_nxt   = 2'd1;
        end
        2'd1: begin
          second_nxt = v;
          bad_nxt    = bad_r | sym_bad;
          cnt_nxt    = 2'd2;
        end
        default: begin
          res_valid  = 1'b1;
          grp_bad    = bad_r | sym_bad;
          code_raw   = ntp_pkg::RADIX_SQ * a8 + ntp_pkg::RADIX * b8 + v8;
          first_nxt  = ntp_pkg::BASE_A;
          second_nxt = ntp_pkg::BASE_A;
          cnt_nxt    = 2'd0;
          bad_nxt    = 1'b0;
        end
      endcase
    end
    res.bad_symbol = grp_bad;
    res.code       = grp_bad ? ntp_pkg::CODE_BAD : code_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= ntp_pkg::BASE_A;
      second_r <= ntp_pkg::BASE_A;
      cnt_r    <= 2'd0;
      bad_r    <= 1'b0;
    end else if (item_fire) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      cnt_r    <= cnt_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

// File: src/nucleotide_triplet_packer.sv
// ----------------------------------------------------------------------------
// nucleotide_triplet_packer: base-5 packing of sequence bytes into group codes
// Input register, packing core and output register.
// ----------------------------------------------------------------------------
// Takes one sequence byte per cycle while in_stall is low and emits a code for
// every third byte and for a flush that finds a partial group. A request is
// registered on entry, its group code is formed from the pending bases and
// lands in the output register. Throughput is one request per cycle while
// in_stall is low; out_stall back-pressures the input only when the output
// register is full and the request in the input register has a result to
// deliver.
module nucleotide_triplet_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ntp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ntp_pkg::out_item_t out_data
);

  logic               s1_valid_r;
  ntp_pkg::in_item_t  s1_item_r;
  logic               core_res_valid;
  ntp_pkg::out_item_t core_res;
  logic               out_free;
  logic               s1_adv;
  logic               out_valid_r;
  ntp_pkg::out_item_t out_data_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!core_res_valid || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  ntp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (s1_adv),
    .item      (s1_item_r),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && core_res_valid) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a flagged group always carries the null code
  a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_symbol |-> out_data.code == ntp_pkg::CODE_BAD)
    else $error("bad group with nonzero code");

  a_triple_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.group_size == ntp_pkg::SIZE_TRIPLE
      |-> out_data.code < ntp_pkg::PAIR_BASE)
    else $error("triplet code out of range");

  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.group_size == ntp_pkg::SIZE_PAIR && !out_data.bad_symbol
      |-> out_data.code >= ntp_pkg::PAIR_BASE && out_data.code < ntp_pkg::SINGLE_BASE)
    else $error("pair code out of range");

  // back-pressure only comes from a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

// File: test/ntp_checker.sv
// ----------------------------------------------------------------------------
// ntp_checker: result predictor and comparator for the triplet packer
// Watches both channels, rebuilds the expected group codes from the accepted
// input requests and compares every accepted result against the oldest one.
// ----------------------------------------------------------------------------
module ntp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ntp_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ntp_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 outstanding
);

  ntp_pkg::base_t     held_a;
  ntp_pkg::base_t     held_b;
  logic [1:0]         held_n;
  logic               held_bad;
  ntp_pkg::out_item_t code_q[$];
  int                 errors = 0;

  // returns {bad, base}; clearing bit 5 folds lower case onto upper case,
  // and only the two letter forms land on each of the five codes
  function automatic logic [3:0] decode_byte(input logic [7:0] ch);
    case (ch & 8'hDF)
      8'h41:   return {1'b0, ntp_pkg::BASE_A};
      8'h43:   return {1'b0, ntp_pkg::BASE_C};
      8'h47:   return {1'b0, ntp_pkg::BASE_G};
      8'h4E:   return {1'b0, ntp_pkg::BASE_N};
      8'h54:   return {1'b0, ntp_pkg::BASE_T};
      default: return {1'b1, ntp_pkg::BASE_A};
    endcase
  endfunction

  task automatic clear_group();
    held_a   = ntp_pkg::BASE_A;
    held_b   = ntp_pkg::BASE_A;
    held_n   = 2'd0;
    held_bad = 1'b0;
  endtask

  task automatic pack_request(input ntp_pkg::in_item_t req);
    logic [3:0]         dec;
    ntp_pkg::out_item_t res;
    if (req.flush) begin
      if (held_n == 2'd0) return;
      res.group_size = held_n;
      res.bad_symbol = held_bad;
      if (held_n == ntp_pkg::SIZE_SINGLE) res.code = ntp_pkg::SINGLE_BASE + held_a;
      else res.code = ntp_pkg::PAIR_BASE + ntp_pkg::RADIX * held_a + held_b;
    end else begin
      dec = decode_byte(req.symbol);
      case (held_n)
        2'd0: begin
          held_a   = dec[2:0];
          held_bad = dec[3];
          held_n   = 2'd1;
          return;
        end
        2'd1: begin
          held_b   = dec[2:0];
          held_bad = held_bad | dec[3];
          held_n   = 2'd2;
          return;
        end
        default: begin
          res.group_size = ntp_pkg::SIZE_TRIPLE;
          res.bad_symbol = held_bad | dec[3];
          res.code       = ntp_pkg::RADIX_SQ * held_a + ntp_pkg::RADIX * held_b
                           + dec[2:0];
        end
      endcase
    end
    if (res.bad_symbol) res.code = ntp_pkg::CODE_BAD;
    code_q.push_back(res);
    clear_group();
  endtask

  always @(posedge clk) begin
    ntp_pkg::out_item_t want;
    if (!rst_n) begin
      clear_group();
      code_q.delete();
    end else begin
      // a result taken at this edge never stems from a request taken at it
      if (out_valid && !out_stall) begin
        if (code_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: code=%0d size=%0d bad=%0b",
                     out_data.code, out_data.group_size, out_data.bad_symbol);
        end else begin
          want = code_q.pop_front();
          if (out_data !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected code=%0d size=%0d bad=%0b, ",
                        "got code=%0d size=%0d bad=%0b"},
                       want.code, want.group_size, want.bad_symbol,
                       out_data.code, out_data.group_size, out_data.bad_symbol);
          end
        end
      end
      if (in_valid && !in_stall) pack_request(in_data);
    end
    fail_count  <= errors;
    outstanding <= code_q.size();
  end

endmodule

// File: test/nucleotide_triplet_packer_tb.sv
// ----------------------------------------------------------------------------
// nucleotide_triplet_packer_tb: top-level bench for the triplet packer
// Directed groups, flushes and bad bytes, then random sequence streams with
// random idling on both sides, a long receiver hold and a full drain.
// ----------------------------------------------------------------------------
module nucleotide_triplet_packer_tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int RANDOM_REQS  = 525;
  localparam string LETTERS   = "ACGNTacgnt";

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ntp_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  ntp_pkg::out_item_t out_data;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 26;
  int rx_idle_pct;
  int hold_req;
  int quiet = 0;

  nucleotide_triplet_packer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ntp_checker packer_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic offer(input logic [7:0] sym, input logic fl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{symbol: sym, flush: fl};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly alphabet letters in either case, the rest any byte at all
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 75) return LETTERS[$urandom_range(9)];
    return 8'($urandom_range(255));
  endfunction

  // receiver: random stalls, plus a long hold whenever one is requested
  initial begin
    int seen_holds;
    seen_holds = 0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req != seen_holds) begin
        seen_holds = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("nucleotide_triplet_packer_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    rx_idle_pct <= 26;
    hold_req    <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    offer(8'h00, 1'b1);                 // flush with nothing held
    put_text("ACG");
    put_text("tna");
    put_text("TTT");                    // top triplet code
    put_text("gN");
    offer(8'hFF, 1'b1);                 // pair flush, symbol field ignored
    put_text("T");
    offer(8'h00, 1'b1);
    put_text("a");
    offer(8'h5A, 1'b1);
    offer(8'h00, 1'b0);                 // bad byte opens a triplet
    put_text("CG");
    put_text("c");
    offer(8'h0A, 1'b0);                 // newline still fills a slot
    offer(8'h00, 1'b1);
    offer(8'hFF, 1'b0);
    offer(8'h00, 1'b1);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 120) begin
        // hold the receiver while requests keep coming, so the block backs up
        hold_req <= hold_req + 1;
        tx_idle_pct = 0;
      end
      if (n == 170) tx_idle_pct = 26;
      if (n == 260) wait_drained();
      if (n == 330) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (n == 450) begin
        tx_idle_pct = 26;
        rx_idle_pct <= 26;
      end
      if ($urandom_range(99) < 10) offer(8'($urandom_range(255)), 1'b1);
      else offer(pick_byte(), 1'b0);
    end
    offer(8'h00, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("nucleotide_triplet_packer_tb: PASS");
    else
      $display("nucleotide_triplet_packer_tb: FAIL");
    $finish;
  end

endmodule

// File: sim.f
src/ntp_pkg.sv
src/ntp_core.sv
src/nucleotide_triplet_packer.sv
test/ntp_checker.sv
test/nucleotide_triplet_packer_tb.sv
